[hw/rtl/bda_pkg.sv]
`timescale 1ns / 1ps
package bda_pkg;

    localparam int MAX_BLOCKS = 64;
    localparam int MAX_ORDER  = 6;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int BLK_LOG2   = $clog2(MAX_BLOCKS + 1) - 1;
    localparam int TOP_MAX    = (MAX_ORDER < BLK_LOG2) ? MAX_ORDER : BLK_LOG2;
    localparam int ORD_W      = 3;
    localparam int BL_W       = 5;
    localparam int BL_MAX     = 16;
    localparam int HDR_W      = 7;
    localparam int OFF_W      = 22;
    localparam int NEED_W     = 24;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;

    localparam logic [1:0] REG_BLOCK_LOG2   = 2'd0;
    localparam logic [1:0] REG_TOP_ORDER    = 2'd1;
    localparam logic [1:0] REG_HEADER_BYTES = 2'd2;

    typedef struct packed {
        logic             head;
        logic             used;
        logic [ORD_W-1:0] order;
    } t_entry;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TOO_LARGE = 2'd1,
        ST_NO_SPACE  = 2'd2,
        ST_BAD_FREE  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_K_STEP,
        OP_SCAN,
        OP_SPLIT,
        OP_A_FIN,
        OP_F_READ,
        OP_F_TAKE,
        OP_F_BUD_RD,
        OP_F_MERGE,
        OP_F_FIN,
        OP_ERR
    } t_op;

    typedef struct packed {
        t_op     op;
        t_status st;
    } t_cmd;

    typedef struct packed {
        logic is_free;
        logic too_big;
        logic k_done;
        logic scan_done;
        logic found;
        logic split_done;
        logic f_bad;
        logic ent_ok;
        logic top_reached;
        logic bud_ok;
    } t_flags;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_A_FIT,
        S_A_K,
        S_A_SCAN,
        S_A_SPLIT,
        S_F_CHK,
        S_F_EVAL,
        S_F_LOOP,
        S_F_BUD,
        S_DONE
    } t_state;

endpackage

[hw/rtl/bda_req_if.sv]
`timescale 1ns / 1ps
interface bda_req_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [21:0] request_bytes;
    logic [21:0] free_offset;

    modport source (output valid, output opcode, output request_bytes,
                    output free_offset, input ready);
    modport sink   (input valid, input opcode, input request_bytes,
                    input free_offset, output ready);
endinterface

[hw/rtl/bda_rsp_if.sv]
`timescale 1ns / 1ps
interface bda_rsp_if;
    logic        valid;
    logic        ready;
    logic [21:0] grant_offset;
    logic [1:0]  status;

    modport source (output valid, output grant_offset, output status, input ready);
    modport sink   (input valid, input grant_offset, input status, output ready);
endinterface

[hw/rtl/bda_dp.sv]
`timescale 1ns / 1ps
module bda_dp
    import bda_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_init,
    input  logic [BL_W-1:0]   i_bl,
    input  logic [ORD_W-1:0]  i_top,
    input  logic [HDR_W-1:0]  i_hdr,
    input  logic              i_opcode,
    input  logic [OFF_W-1:0]  i_request_bytes,
    input  logic [OFF_W-1:0]  i_free_offset,
    input  t_cmd              i_cmd,
    output t_flags            o_flags,
    output logic [OFF_W-1:0]  o_res_off,
    output t_status           o_res_st
);

    t_entry             r_mem [MAX_BLOCKS];
    logic [MAX_BLOCKS-1:0] r_vld;
    t_entry             r_rd;
    logic [IDX_W-1:0]   r_rd_addr;
    logic               r_rdv;

    logic               r_op_free;
    logic [NEED_W-1:0]  r_need;
    logic [OFF_W-1:0]   r_off;
    logic [ORD_W-1:0]   r_k;
    logic [CNT_W-1:0]   r_idx;
    logic               r_found;
    logic [IDX_W-1:0]   r_best;
    logic [ORD_W-1:0]   r_best_ord;
    logic [IDX_W-1:0]   r_cur;
    logic [ORD_W-1:0]   r_ord;
    logic [OFF_W-1:0]   r_res_off;
    t_status            r_res_st;

    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               we;
    logic [IDX_W-1:0]   wa;
    t_entry             wd;
    t_entry             dflt;

    logic [CNT_W-1:0]   nblk;
    logic [5:0]         sh_pool;
    logic [5:0]         sh_k;
    logic [OFF_W-1:0]   rel;
    logic [OFF_W-1:0]   f_idx;
    logic [OFF_W-1:0]   mask;
    logic [IDX_W-1:0]   bud;
    logic [ORD_W-1:0]   split_o;
    logic               cand;

    assign nblk    = CNT_W'(1) << i_top;
    assign sh_pool = {1'b0, i_bl} + {3'b0, i_top};
    assign sh_k    = {1'b0, i_bl} + {3'b0, r_k};
    assign rel     = r_off - OFF_W'(i_hdr);
    assign f_idx   = rel >> i_bl;
    assign mask    = (OFF_W'(1) << i_bl) - OFF_W'(1);
    assign bud     = r_cur ^ (IDX_W'(1) << r_ord);
    assign split_o = r_best_ord - ORD_W'(1);
    assign cand    = r_rdv && r_rd.head && !r_rd.used && (r_rd.order >= r_k)
                     && (!r_found || (r_rd.order < r_best_ord));

    always_comb begin
        o_flags.is_free     = r_op_free;
        o_flags.too_big     = r_need > (NEED_W'(1) << sh_pool);
        o_flags.k_done      = !((r_k < i_top) && (r_need > (NEED_W'(1) << sh_k)));
        o_flags.scan_done   = (r_idx == nblk) && !r_rdv;
        o_flags.found       = r_found;
        o_flags.split_done  = (r_best_ord <= r_k);
        o_flags.f_bad       = (r_off < OFF_W'(i_hdr)) || ((rel & mask) != '0)
                              || (f_idx >= OFF_W'(nblk));
        o_flags.ent_ok      = r_rd.head && r_rd.used;
        o_flags.top_reached = (r_ord >= i_top);
        o_flags.bud_ok      = r_rd.head && !r_rd.used && (r_rd.order == r_ord);
    end

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_idx[IDX_W-1:0];
        we      = 1'b0;
        wa      = r_cur;
        wd      = '0;
        unique case (i_cmd.op)
            OP_SCAN: begin
                rd_en = (r_idx < nblk);
            end
            OP_F_READ: begin
                rd_en   = 1'b1;
                rd_addr = f_idx[IDX_W-1:0];
            end
            OP_F_BUD_RD: begin
                rd_en   = 1'b1;
                rd_addr = bud;
            end
            OP_SPLIT: begin
                we = 1'b1;
                wa = r_best + (IDX_W'(1) << split_o);
                wd = '{head: 1'b1, used: 1'b0, order: split_o};
            end
            OP_A_FIN: begin
                we = 1'b1;
                wa = r_best;
                wd = '{head: 1'b1, used: 1'b1, order: r_k};
            end
            OP_F_MERGE: begin
                we = 1'b1;
                wa = (r_cur > bud) ? r_cur : bud;
                wd = '0;
            end
            OP_F_FIN: begin
                we = 1'b1;
                wa = r_cur;
                wd = '{head: 1'b1, used: 1'b0, order: r_ord};
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        dflt = '0;
        if (rd_addr == '0) begin
            dflt = '{head: 1'b1, used: 1'b0, order: i_top};
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd      <= r_vld[rd_addr] ? r_mem[rd_addr] : dflt;
            r_rd_addr <= rd_addr;
        end
        if (we) begin
            r_mem[wa] <= wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_init) begin
            r_vld <= '0;
        end else if (we) begin
            r_vld[wa] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rdv   <= 1'b0;
            r_found <= 1'b0;
        end else begin
            unique case (i_cmd.op)
                OP_LOAD: begin
                    r_op_free <= i_opcode;
                    r_need    <= NEED_W'(i_request_bytes) + NEED_W'(i_hdr);
                    r_off     <= i_free_offset;
                    r_k       <= '0;
                    r_idx     <= '0;
                    r_found   <= 1'b0;
                    r_rdv     <= 1'b0;
                end
                OP_K_STEP: begin
                    r_k <= r_k + ORD_W'(1);
                end
                OP_SCAN: begin
                    r_rdv <= rd_en;
                    if (rd_en) begin
                        r_idx <= r_idx + CNT_W'(1);
                    end
                    if (cand) begin
                        r_found    <= 1'b1;
                        r_best     <= r_rd_addr;
                        r_best_ord <= r_rd.order;
                    end
                end
                OP_SPLIT: begin
                    r_best_ord <= split_o;
                end
                OP_A_FIN: begin
                    r_res_off <= OFF_W'((NEED_W'(r_best) << i_bl) + NEED_W'(i_hdr));
                    r_res_st  <= ST_OK;
                end
                OP_F_READ: begin
                    r_cur <= f_idx[IDX_W-1:0];
                end
                OP_F_TAKE: begin
                    r_ord <= r_rd.order;
                end
                OP_F_MERGE: begin
                    r_cur <= (r_cur < bud) ? r_cur : bud;
                    r_ord <= r_ord + ORD_W'(1);
                end
                OP_F_FIN: begin
                    r_res_off <= '0;
                    r_res_st  <= ST_OK;
                end
                OP_ERR: begin
                    r_res_off <= '0;
                    r_res_st  <= i_cmd.st;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_res_off = r_res_off;
    assign o_res_st  = r_res_st;

endmodule

[hw/rtl/bda_ctrl.sv]
`timescale 1ns / 1ps
module bda_ctrl
    import bda_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    input  logic   i_out_free,
    input  t_flags i_flags,
    output logic   o_in_ready,
    output logic   o_push,
    output t_cmd   o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd.op   = OP_NONE;
        o_cmd.st   = ST_OK;
        o_in_ready = 1'b0;
        o_push     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_state = i_flags.is_free ? S_F_CHK : S_A_FIT;
            end
            S_A_FIT: begin
                if (i_flags.too_big) begin
                    o_cmd.op = OP_ERR;
                    o_cmd.st = ST_TOO_LARGE;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_A_K;
                end
            end
            S_A_K: begin
                if (i_flags.k_done) begin
                    n_state = S_A_SCAN;
                end else begin
                    o_cmd.op = OP_K_STEP;
                end
            end
            S_A_SCAN: begin
                if (!i_flags.scan_done) begin
                    o_cmd.op = OP_SCAN;
                end else if (i_flags.found) begin
                    n_state = S_A_SPLIT;
                end else begin
                    o_cmd.op = OP_ERR;
                    o_cmd.st = ST_NO_SPACE;
                    n_state  = S_DONE;
                end
            end
            S_A_SPLIT: begin
                if (i_flags.split_done) begin
                    o_cmd.op = OP_A_FIN;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.op = OP_SPLIT;
                end
            end
            S_F_CHK: begin
                if (i_flags.f_bad) begin
                    o_cmd.op = OP_ERR;
                    o_cmd.st = ST_BAD_FREE;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.op = OP_F_READ;
                    n_state  = S_F_EVAL;
                end
            end
            S_F_EVAL: begin
                if (i_flags.ent_ok) begin
                    o_cmd.op = OP_F_TAKE;
                    n_state  = S_F_LOOP;
                end else begin
                    o_cmd.op = OP_ERR;
                    o_cmd.st = ST_BAD_FREE;
                    n_state  = S_DONE;
                end
            end
            S_F_LOOP: begin
                if (i_flags.top_reached) begin
                    o_cmd.op = OP_F_FIN;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.op = OP_F_BUD_RD;
                    n_state  = S_F_BUD;
                end
            end
            S_F_BUD: begin
                if (i_flags.bud_ok) begin
                    o_cmd.op = OP_F_MERGE;
                    n_state  = S_F_LOOP;
                end else begin
                    o_cmd.op = OP_F_FIN;
                    n_state  = S_DONE;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_push  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/buddy_allocator_unit.sv]
`timescale 1ns / 1ps
// Allocate: order steps, then one pass over the block table, then one split per order
// above the target; too large is rejected before these steps.
// Free: one buddy read and merge per merge level; a rejected free ends at the check.
// One item at a time; the next is taken while the last result waits.
// Synchronous active-low reset clears control, config to defaults, and the
// table valid bits (instant reinit; also on a top_order write).
module buddy_allocator_unit
    import bda_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    bda_req_if.sink           i_req,
    bda_rsp_if.source         o_rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic [BL_W-1:0]  r_block_log2;
    logic [ORD_W-1:0] r_top_order;
    logic [HDR_W-1:0] r_header_bytes;
    logic             r_out_vld;
    logic [OFF_W-1:0] r_out_off;
    t_status          r_out_st;

    logic             wr;
    logic             init;
    logic [BL_W-1:0]  bl_eff;
    logic [ORD_W-1:0] top_eff;
    t_cmd             cmd;
    t_flags           flags;
    logic             push;
    logic             out_free;
    logic [OFF_W-1:0] res_off;
    t_status          res_st;

    assign pready  = 1'b1;
    assign wr      = psel && penable && pwrite;
    assign init    = wr && (paddr[3:2] == REG_TOP_ORDER);
    assign bl_eff  = (r_block_log2 > BL_W'(BL_MAX)) ? BL_W'(BL_MAX) : r_block_log2;
    assign top_eff = (r_top_order > ORD_W'(TOP_MAX)) ? ORD_W'(TOP_MAX) : r_top_order;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_log2   <= BL_W'(7);
            r_top_order    <= ORD_W'(6);
            r_header_bytes <= HDR_W'(16);
        end else if (wr) begin
            unique case (paddr[3:2])
                REG_BLOCK_LOG2:   r_block_log2   <= pwdata[BL_W-1:0];
                REG_TOP_ORDER:    r_top_order    <= pwdata[ORD_W-1:0];
                REG_HEADER_BYTES: r_header_bytes <= pwdata[HDR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_BLOCK_LOG2:   prdata = DATA_W'(r_block_log2);
            REG_TOP_ORDER:    prdata = DATA_W'(r_top_order);
            REG_HEADER_BYTES: prdata = DATA_W'(r_header_bytes);
            default:          prdata = '0;
        endcase
    end

    assign out_free = !r_out_vld || o_rsp.ready;

    bda_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_out_free (out_free),
        .i_flags    (flags),
        .o_in_ready (i_req.ready),
        .o_push     (push),
        .o_cmd      (cmd)
    );

    bda_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_init          (init),
        .i_bl            (bl_eff),
        .i_top           (top_eff),
        .i_hdr           (r_header_bytes),
        .i_opcode        (i_req.opcode),
        .i_request_bytes (i_req.request_bytes),
        .i_free_offset   (i_req.free_offset),
        .i_cmd           (cmd),
        .o_flags         (flags),
        .o_res_off       (res_off),
        .o_res_st        (res_st)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (push) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_out_off <= res_off;
            r_out_st  <= res_st;
        end
    end

    assign o_rsp.valid        = r_out_vld;
    assign o_rsp.grant_offset = r_out_off;
    assign o_rsp.status       = r_out_st;

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
    import bda_pkg::*;

    localparam logic OPC_ALLOC = 1'b0;
    localparam logic OPC_FREE  = 1'b1;

    typedef struct packed {
        logic [21:0] grant_offset;
        t_status     status;
    } t_grant;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;

    bda_req_if req_if ();
    bda_rsp_if rsp_if ();

    buddy_allocator_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_if.sink), .o_rsp(rsp_if.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #6 i_clk = ~i_clk;

    // predictor state
    logic        tbl_head [MAX_BLOCKS];
    logic        tbl_used [MAX_BLOCKS];
    int unsigned tbl_ord  [MAX_BLOCKS];
    int unsigned cfg_bl, cfg_top, cfg_hdr;
    t_grant      grants_due [$];
    int unsigned live_offs [$];
    int          errors = 0;
    logic        stall_mode = 1'b0;

    function automatic int unsigned pool_order();
        int unsigned t;
        t = (cfg_top > MAX_ORDER) ? MAX_ORDER : cfg_top;
        while (t > 0 && (1 << t) > MAX_BLOCKS) t--;
        return t;
    endfunction

    function automatic int unsigned unit_log2();
        return (cfg_bl > BL_MAX) ? BL_MAX : cfg_bl;
    endfunction

    function automatic void clear_table();
        for (int i = 0; i < MAX_BLOCKS; i++) begin
            tbl_head[i] = 1'b0;
            tbl_used[i] = 1'b0;
            tbl_ord[i]  = 0;
        end
        tbl_head[0] = 1'b1;
        tbl_ord[0]  = pool_order();
    endfunction

    function automatic t_grant predict_alloc(int unsigned req);
        t_grant g;
        int unsigned bl, top, nblk, k, found, o, up;
        longint unsigned need;
        bl = unit_log2();
        top = pool_order();
        nblk = 1 << top;
        need = longint'(req) + cfg_hdr;
        g = '{grant_offset: '0, status: ST_OK};
        if (need > (64'd1 << (bl + top))) begin
            g.status = ST_TOO_LARGE;
            return g;
        end
        k = 0;
        while (k < top && need > (64'd1 << (bl + k))) k++;
        found = nblk;
        for (int unsigned j = k; j <= top && found == nblk; j++)
            for (int unsigned i = 0; i < nblk; i++)
                if (found == nblk && tbl_head[i] && !tbl_used[i] && tbl_ord[i] == j)
                    found = i;
        if (found == nblk) begin
            g.status = ST_NO_SPACE;
            return g;
        end
        while (tbl_ord[found] > k) begin
            o = tbl_ord[found] - 1;
            up = found + (1 << o);
            tbl_ord[found] = o;
            if (up < MAX_BLOCKS) begin
                tbl_head[up] = 1'b1;
                tbl_used[up] = 1'b0;
                tbl_ord[up] = o;
            end
        end
        tbl_used[found] = 1'b1;
        g.grant_offset = 22'((longint'(found) << bl) + cfg_hdr);
        return g;
    endfunction

    function automatic t_grant predict_free(int unsigned off);
        t_grant g;
        int unsigned bl, top, idx, o, bud, low;
        longint unsigned rel;
        bl = unit_log2();
        top = pool_order();
        g = '{grant_offset: '0, status: ST_BAD_FREE};
        if (off < cfg_hdr) return g;
        rel = off - cfg_hdr;
        if ((rel & ((64'd1 << bl) - 1)) != 0 || (rel >> bl) >= (64'd1 << top)) return g;
        idx = int'(rel >> bl);
        if (!tbl_head[idx] || !tbl_used[idx]) return g;
        tbl_used[idx] = 1'b0;
        while (tbl_ord[idx] < top) begin
            o = tbl_ord[idx];
            bud = idx ^ (1 << o);
            if (bud >= MAX_BLOCKS) break;
            if (!tbl_head[bud] || tbl_used[bud] || tbl_ord[bud] != o) break;
            low = (idx < bud) ? idx : bud;
            tbl_head[idx] = 1'b0; tbl_ord[idx] = 0;
            tbl_head[bud] = 1'b0; tbl_ord[bud] = 0;
            tbl_head[low] = 1'b1; tbl_used[low] = 1'b0; tbl_ord[low] = o + 1;
            idx = low;
        end
        g.status = ST_OK;
        return g;
    endfunction

    // response side: stall pattern plus checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                t_grant exp_g;
                if (grants_due.size() == 0) begin
                    $display("%0t unexpected item: offset %0d status %0d", $time,
                             rsp_if.grant_offset, rsp_if.status);
                    errors++;
                end else begin
                    exp_g = grants_due.pop_front();
                    if (rsp_if.grant_offset !== exp_g.grant_offset) begin
                        $display("%0t grant_offset expected %0d actual %0d", $time,
                                 exp_g.grant_offset, rsp_if.grant_offset);
                        errors++;
                    end
                    if (rsp_if.status !== exp_g.status) begin
                        $display("%0t status expected %0d actual %0d", $time,
                                 exp_g.status, rsp_if.status);
                        errors++;
                    end
                end
            end
            if (stall_mode)
                rsp_if.ready <= ($urandom_range(0, 9) > 3) && ($time % 84 > 12);
            else
                rsp_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && $urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;

    int burst_left = 0;

    task automatic send_item(input logic opc, input int unsigned req, input int unsigned off);
        t_grant g;
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        req_if.valid <= 1'b1;
        req_if.opcode <= opc;
        req_if.request_bytes <= 22'(req);
        req_if.free_offset <= 22'(off);
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        if (opc == OPC_ALLOC) begin
            g = predict_alloc(req);
            if (g.status == ST_OK) live_offs.push_back(g.grant_offset);
        end else begin
            g = predict_free(off);
        end
        grants_due.push_back(g);
        if (burst_left == 0) req_if.valid <= 1'b0;
    endtask

    task automatic drain();
        if (burst_left != 0) req_if.valid <= 1'b0;
        burst_left = 0;
        while (grants_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input int unsigned val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= ADDR_W'(idx) << 2; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_BLOCK_LOG2:   cfg_bl = val & 5'h1f;
            REG_TOP_ORDER: begin
                cfg_top = val & 3'h7;
                clear_table();
                live_offs.delete();
            end
            REG_HEADER_BYTES: cfg_hdr = val & 7'h7f;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic setup(input int unsigned bl, input int unsigned top, input int unsigned hdr);
        drain();
        reg_write(REG_BLOCK_LOG2, bl);
        reg_write(REG_HEADER_BYTES, hdr);
        reg_write(REG_TOP_ORDER, top);
    endtask

    task automatic free_random_live();
        int unsigned p, off;
        p = $urandom_range(0, live_offs.size() - 1);
        off = live_offs[p];
        live_offs.delete(p);
        send_item(OPC_FREE, 0, off);
    endtask

    task automatic test_directed();
        send_item(OPC_ALLOC, 0, 0);
        send_item(OPC_ALLOC, 4194303, 0);
        send_item(OPC_ALLOC, (1 << 13) - 16, 0);
        send_item(OPC_FREE, 0, 4194303);
        send_item(OPC_FREE, 0, 0);
        send_item(OPC_FREE, 0, 17);
        free_random_live();
        send_item(OPC_ALLOC, (1 << 13) - 16, 0);
        send_item(OPC_ALLOC, 1, 0);
        free_random_live();
        send_item(OPC_FREE, 0, 16);
        send_item(OPC_FREE, 0, 16);
        drain();
        for (int i = 0; i < 5; i++) send_item(OPC_ALLOC, 100, 0);
        send_item(OPC_FREE, 0, 16 + 128 * 64);
        send_item(OPC_FREE, 0, 16 + 128 * 3);
        while (live_offs.size() != 0) free_random_live();
        // full pool then exhaustion
        send_item(OPC_ALLOC, 8000, 0);
        send_item(OPC_ALLOC, 0, 0);
        free_random_live();
    endtask

    task automatic test_limits();
        setup(31, 7, 127);
        send_item(OPC_ALLOC, 4194303, 0);
        send_item(OPC_ALLOC, 65536 - 127, 0);
        send_item(OPC_ALLOC, 0, 0);
        send_item(OPC_FREE, 0, 127 + 65536 * 2);
        send_item(OPC_FREE, 0, 127);
        send_item(OPC_FREE, 0, 126);
        setup(4, 0, 0);
        send_item(OPC_ALLOC, 16, 0);
        send_item(OPC_ALLOC, 17, 0);
        send_item(OPC_ALLOC, 0, 0);
        send_item(OPC_FREE, 0, 0);
        send_item(OPC_FREE, 0, 16);
        setup(4, 3, 64);
        send_item(OPC_ALLOC, 0, 0);
        send_item(OPC_ALLOC, 100, 0);
        while (live_offs.size() != 0) free_random_live();
    endtask

    task automatic test_random(input int count);
        int unsigned sz, r, lim;
        for (int n = 0; n < count; n++) begin
            if (n % 130 == 0) begin
                setup($urandom_range(4, 16) + (($urandom_range(0, 5) == 0) ? 15 : 0),
                      $urandom_range(0, 7), $urandom_range(0, 127));
            end
            if (n == count / 2) drain();
            r = $urandom_range(0, 19);
            lim = (1 << (unit_log2() + pool_order()));
            if (r < 9) begin
                sz = $urandom_range(0, lim >> $urandom_range(0, 7));
                send_item(OPC_ALLOC, sz, 0);
            end else if (r < 16 && live_offs.size() != 0) begin
                free_random_live();
            end else if (r < 18) begin
                send_item(OPC_ALLOC, $urandom_range(0, 22'h3fffff), 0);
            end else begin
                send_item(OPC_FREE, 0, $urandom_range(0, 22'h3fffff) >> $urandom_range(0, 14));
            end
        end
        while (live_offs.size() != 0) free_random_live();
    endtask

    initial begin
        req_if.valid = 1'b0;
        req_if.opcode = 1'b0;
        req_if.request_bytes = '0;
        req_if.free_offset = '0;
        cfg_bl = 7; cfg_top = 6; cfg_hdr = 16;
        clear_table();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_limits();
        test_random(600);
        drain();
        repeat (200) @(posedge i_clk);
        if (errors == 0 && grants_due.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("Some tests failed");
        $finish;
    end
endmodule

[files.f]
hw/rtl/bda_pkg.sv
hw/rtl/bda_req_if.sv
hw/rtl/bda_rsp_if.sv
hw/rtl/bda_dp.sv
hw/rtl/bda_ctrl.sv
hw/rtl/buddy_allocator_unit.sv
tb/tb_top.sv
